// File: rtl/core/deq_pkg.sv
package deq_pkg;

	// ring size and derived widths
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int DATA_W = 32;

	// request codes
	localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
	localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
	localparam logic [1:0] CMD_POP_BACK   = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_cmd_t;

endpackage

// File: rtl/core/deq_ctrl.sv
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output deq_pkg::ctl_cmd_t  ctl
);
	import deq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (m_tready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// handshake and datapath commands
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign ctl.load = s_tready && s_tvalid;
	assign ctl.exec = (state_q == S_EXEC);

endmodule

// File: rtl/core/deq_dp.sv
module deq_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  deq_pkg::ctl_cmd_t               ctl,
	input  logic [1:0]                      cmd,
	input  logic signed [deq_pkg::DATA_W-1:0] push_value,
	output logic signed [deq_pkg::DATA_W-1:0] pop_value,
	output logic [1:0]                      status
);
	import deq_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [1:0]        cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] rdata_q;
	logic [1:0]        status_q;
	logic              pop_ok_q;

	logic              full;
	logic              empty;
	logic [IDX_W-1:0]  front_dec;
	logic [IDX_W-1:0]  front_inc;
	logic [SUM_W-1:0]  back_sum;
	logic [SUM_W-1:0]  last_sum;
	logic [IDX_W-1:0]  back_idx;
	logic [IDX_W-1:0]  last_idx;
	logic [IDX_W-1:0]  addr;
	logic              wr_en;
	logic              ok;
	logic [1:0]        status_d;
	logic [IDX_W-1:0]  front_d;
	logic [CNT_W-1:0]  count_d;

	// request capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			val_q <= push_value;
		end
	end

	// ring index arithmetic
	always_comb begin
		full      = (count_q == CNT_W'(DEPTH));
		empty     = (count_q == '0);
		front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
		front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
		back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
		last_sum  = back_sum - 1'b1;
		back_idx  = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
		                                        : IDX_W'(back_sum);
		last_idx  = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
		                                        : IDX_W'(last_sum);
	end

	// per-request address, status and next indices
	always_comb begin
		addr     = front_q;
		wr_en    = 1'b0;
		ok       = 1'b0;
		status_d = STAT_OK;
		front_d  = front_q;
		count_d  = count_q;
		case (cmd_q)
			CMD_PUSH_FRONT: begin
				addr = front_dec;
				if (full) begin
					status_d = STAT_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					front_d = front_dec;
					count_d = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				addr = back_idx;
				if (full) begin
					status_d = STAT_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				addr = front_q;
				if (empty) begin
					status_d = STAT_UNDERFLOW;
				end else begin
					ok      = 1'b1;
					front_d = front_inc;
					count_d = count_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				addr = last_idx;
				if (empty) begin
					status_d = STAT_UNDERFLOW;
				end else begin
					ok      = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				addr = front_q;
			end
		endcase
	end

	// ring store, registered read
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (wr_en) mem[addr] <= val_q;
			rdata_q <= mem[addr];
		end
	end

	// ring indices and result status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			status_q <= STAT_OK;
			pop_ok_q <= 1'b0;
		end else if (ctl.exec) begin
			front_q  <= front_d;
			count_q  <= count_d;
			status_q <= status_d;
			pop_ok_q <= ok;
		end
	end

	assign pop_value = pop_ok_q ? rdata_q : '0;
	assign status    = status_q;

endmodule

// File: rtl/core/double_ended_queue.sv
// channel  | dir | fields (low bit first)            | handshake
// ---------+-----+-----------------------------------+----------------------
// s_       | in  | tdata: push_value[31:0]           | s_tvalid / s_tready
//          |     | tuser: cmd[1:0]                   |
// m_       | out | tdata: pop_value[31:0]            | m_tvalid / m_tready
//          |     | tuser: status[1:0]                |
//
// one request at a time (single-request controller): accept, then the ring
// store access with a registered read, then the result is held on m_ until taken.
// arst_n clears the front index, the count and the controller; the store itself
// is not cleared. s_tready stays low from acceptance until the result is taken.
module double_ended_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // push_value[31:0]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // pop_value[31:0]
	output logic [1:0]  m_tuser   // status[1:0]
);
	import deq_pkg::*;

	ctl_cmd_t                 ctl;
	logic signed [DATA_W-1:0] pop_value;

	// controller
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl)
	);

	// datapath
	deq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cmd        (s_tuser),
		.push_value (s_tdata),
		.pop_value  (pop_value),
		.status     (m_tuser)
	);

	assign m_tdata = pop_value;

endmodule

// File: rtl/core/deq_check.sv
module deq_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import deq_pkg::*;

	// one request in flight: no new request until the result is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// an accepted request passes through the execute state, then its result is shown
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ##1 m_tvalid)
		else $error("result missing after request");

	// a taken result is not shown again
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("result repeated");

	// status code is one of the defined ones
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_UNDERFLOW ||
		              m_tuser == STAT_OVERFLOW))
		else $error("bad status code");

	// failed requests carry a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
		else $error("nonzero value on failed request");

endmodule

bind double_ended_queue deq_check u_deq_check (.*);
